/* sv/ms_adpcm_block_decoder_unit_macros.svh */
// assertion macros for the ms adpcm block decoder
// expects clk and arst_n in the scope of the including module
`ifndef MS_ADPCM_BLOCK_DECODER_UNIT_MACROS_SVH
`define MS_ADPCM_BLOCK_DECODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define MSADPCM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define MSADPCM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/msadpcm_pkg.sv */
// shared types, constants and tables for the ms adpcm block decoder
// no dependencies
package msadpcm_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;
	localparam int CHAN_W = 2;
	localparam int BPC_W  = 13;
	localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd1;
	localparam logic [BPC_W-1:0]  BPC_RESET  = 13'd256;
	localparam int BPC_MIN     = 8;
	localparam int HDR_PER_CH  = 7;
	localparam logic [7:0] COEF_IDX_MAX = 8'd6;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);

	// sample and scale limits
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [31:0] SCALE_MIN  = 32'sd16;
	localparam logic signed [31:0] SCALE_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [27:0] TRUNC_BIAS = 28'sd255;

	// kind of work for the back end
	typedef enum logic [2:0] {
		OP_COEF  = 3'd0,
		OP_SCALE = 3'd1,
		OP_PREV  = 3'd2,
		OP_OLDER = 3'd3,
		OP_DATA  = 3'd4
	} op_t;

	// one queued item
	typedef struct packed {
		op_t         op;
		logic        ch;
		logic        ch2;
		logic        last;
		logic        bad;
		logic [15:0] data;
	} qent_t;

	// step adaptation table
	function automatic logic [9:0] adapt_of(input logic [3:0] nib);
		logic [9:0] v;
		unique case (nib)
			4'd0, 4'd1, 4'd2, 4'd3: v = 10'd230;
			4'd4:  v = 10'd307;
			4'd5:  v = 10'd409;
			4'd6:  v = 10'd512;
			4'd7:  v = 10'd614;
			4'd8:  v = 10'd768;
			4'd9:  v = 10'd614;
			4'd10: v = 10'd512;
			4'd11: v = 10'd409;
			4'd12: v = 10'd307;
			default: v = 10'd230;
		endcase
		return v;
	endfunction

	// first predictor coefficient
	function automatic logic signed [10:0] coef1_of(input logic [2:0] idx);
		logic signed [10:0] v;
		unique case (idx)
			3'd0: v = 11'sd256;
			3'd1: v = 11'sd512;
			3'd2: v = 11'sd0;
			3'd3: v = 11'sd192;
			3'd4: v = 11'sd240;
			3'd5: v = 11'sd460;
			3'd6: v = 11'sd392;
			default: v = 11'sd256;
		endcase
		return v;
	endfunction

	// second predictor coefficient
	function automatic logic signed [8:0] coef2_of(input logic [2:0] idx);
		logic signed [8:0] v;
		unique case (idx)
			3'd0: v = 9'sd0;
			3'd1: v = -9'sd256;
			3'd2: v = 9'sd0;
			3'd3: v = 9'sd64;
			3'd4: v = 9'sd0;
			3'd5: v = -9'sd208;
			3'd6: v = -9'sd232;
			default: v = 9'sd0;
		endcase
		return v;
	endfunction

endpackage

/* sv/msadpcm_front.sv */
// front end: configuration registers, block position tracking, byte classification
// depends on msadpcm_pkg
module msadpcm_front #(
	parameter int MAX_BLOCK_BYTES = 4096,
	parameter int MAX_CHANNELS    = 2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            stream_byte,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [msadpcm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msadpcm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                  q_full,
	output logic                                  push,
	output msadpcm_pkg::qent_t                    entry
);

	localparam int TOT_MAX = MAX_BLOCK_BYTES * MAX_CHANNELS;
	localparam int POS_W   = $clog2(TOT_MAX);
	localparam int TOT_W   = POS_W + 1;

	logic [msadpcm_pkg::CHAN_W-1:0] chan_q;
	logic [msadpcm_pkg::BPC_W-1:0]  bpc_q;
	logic [POS_W-1:0]               pos_q;
	logic [7:0]                     hold_q;
	logic                           bad_q;

	logic              eff_two;
	logic [31:0]       bpc_raw;
	logic [31:0]       bpc_sat;
	logic [TOT_W-1:0]  total;
	logic [TOT_W-1:0]  nch;
	logic [TOT_W-1:0]  hdr;
	logic [TOT_W-1:0]  pos_ext;
	logic [TOT_W-1:0]  q_diff;
	logic [3:0]        q4;
	logic [2:0]        f;
	logic [1:0]        grp;
	logic              hch;
	logic              last;
	logic              is_coef;
	logic              is_hdr;
	logic              bad_idx;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= msadpcm_pkg::CHAN_RESET;
			bpc_q  <= msadpcm_pkg::BPC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				msadpcm_pkg::CFG_CHANNELS:    chan_q <= cfg_data[msadpcm_pkg::CHAN_W-1:0];
				msadpcm_pkg::CFG_BLOCK_BYTES: bpc_q  <= cfg_data;
			endcase
		end
	end

	// effective channel count and block length
	always_comb begin
		eff_two = (chan_q >= 2'd2) && (MAX_CHANNELS >= 2);
		bpc_raw = 32'(bpc_q);
		priority if (bpc_raw < 32'(msadpcm_pkg::BPC_MIN))
			bpc_sat = 32'(msadpcm_pkg::BPC_MIN);
		else if (bpc_raw > 32'(MAX_BLOCK_BYTES))
			bpc_sat = 32'(MAX_BLOCK_BYTES);
		else
			bpc_sat = bpc_raw;
		total = eff_two ? TOT_W'(bpc_sat << 1) : TOT_W'(bpc_sat);
		nch   = eff_two ? TOT_W'(2) : TOT_W'(1);
		hdr   = eff_two ? TOT_W'(2 * msadpcm_pkg::HDR_PER_CH)
		                : TOT_W'(msadpcm_pkg::HDR_PER_CH);
	end

	// position decode
	always_comb begin
		pos_ext = TOT_W'(pos_q);
		last    = (pos_ext + TOT_W'(1)) >= total;
		is_coef = pos_ext < nch;
		is_hdr  = pos_ext < hdr;
		q_diff  = pos_ext - nch;
		q4      = q_diff[3:0];
		f       = q4[3:1];
		grp     = eff_two ? f[2:1] : f[1:0];
		hch     = eff_two ? f[0] : 1'b0;
		bad_idx = stream_byte > msadpcm_pkg::COEF_IDX_MAX;
	end

	// build the queued item
	always_comb begin
		entry.ch2  = eff_two;
		entry.last = last;
		entry.bad  = bad_q;
		priority if (is_coef) begin
			entry.op   = msadpcm_pkg::OP_COEF;
			entry.ch   = pos_q[0];
			entry.data = bad_idx ? 16'd0 : {8'd0, stream_byte};
		end else if (is_hdr) begin
			priority if (grp == 2'd0)
				entry.op = msadpcm_pkg::OP_SCALE;
			else if (grp == 2'd1)
				entry.op = msadpcm_pkg::OP_PREV;
			else
				entry.op = msadpcm_pkg::OP_OLDER;
			entry.ch   = hch;
			entry.data = {stream_byte, hold_q};
		end else begin
			entry.op   = msadpcm_pkg::OP_DATA;
			entry.ch   = 1'b0;
			entry.data = {8'd0, stream_byte};
		end
	end

	// low halves of header words stay in the front
	assign push = accept && (is_coef || !is_hdr || q4[0]);

	// position, flag and low byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			bad_q  <= 1'b0;
			hold_q <= '0;
		end else if (accept) begin
			pos_q <= last ? '0 : pos_q + POS_W'(1);
			bad_q <= ((pos_q == '0) ? 1'b0 : bad_q) | (is_coef && bad_idx);
			if (is_hdr && !is_coef && !q4[0])
				hold_q <= stream_byte;
		end
	end

endmodule

/* sv/msadpcm_queue.sv */
// short fifo of classified items between front and back
// depends on msadpcm_pkg
module msadpcm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  msadpcm_pkg::qent_t  push_ent,
	input  logic                pop,
	output msadpcm_pkg::qent_t  head,
	output logic                full,
	output logic                empty
);

	msadpcm_pkg::qent_t                 slot_q [msadpcm_pkg::QDEPTH];
	logic [msadpcm_pkg::QA_W-1:0]      wr_q;
	logic [msadpcm_pkg::QA_W-1:0]      rd_q;
	logic [msadpcm_pkg::QA_W:0]        cnt_q;

	assign full  = cnt_q == (msadpcm_pkg::QA_W + 1)'(msadpcm_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_ent;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/msadpcm_back.sv */
// back end: channel state, two-stage nibble decoder, output register
// depends on msadpcm_pkg
module msadpcm_back #(
	parameter int MAX_CHANNELS = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  msadpcm_pkg::qent_t  head,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  pcm_sample,
	output logic                sample_channel,
	output logic                last_of_byte,
	output logic                end_of_block,
	output logic                bad_coeff_index
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FIN_HI = 4'b0010,
		ST_MUL_LO = 4'b0100,
		ST_FIN_LO = 4'b1000
	} st_t;

	st_t state_q;
	st_t state_d;

	// channel state
	logic signed [10:0] c1_q    [MAX_CHANNELS];
	logic signed [8:0]  c2_q    [MAX_CHANNELS];
	logic signed [31:0] scale_q [MAX_CHANNELS];
	logic signed [15:0] prev_q  [MAX_CHANNELS];
	logic signed [15:0] older_q [MAX_CHANNELS];

	// byte in progress
	logic [7:0] cur_byte_q;
	logic       cur_ch2_q;
	logic       cur_last_q;
	logic       cur_bad_q;

	// product stage
	logic signed [26:0] prod1_s1;
	logic signed [24:0] prod2_s1;
	logic signed [35:0] step_s1;
	logic signed [42:0] adapt_s1;
	logic               ch_s1;

	// output register
	logic               out_valid_q;
	logic signed [15:0] pcm_q;
	logic               chan_q;
	logic               lob_q;
	logic               eob_q;
	logic               bad_q;

	logic               head_go;
	logic               mul_go;
	logic               fin_go;
	logic               out_free;
	logic               mul_ch;
	logic [3:0]         mul_nib;
	logic signed [3:0]  sn;
	logic signed [10:0] c1_sel;
	logic signed [8:0]  c2_sel;
	logic signed [31:0] scale_sel;
	logic signed [15:0] prev_sel;
	logic signed [15:0] older_sel;
	logic signed [10:0] adapt_sgn;
	logic signed [27:0] sum;
	logic signed [27:0] sum_b;
	logic signed [19:0] quot;
	logic signed [36:0] pred;
	logic signed [15:0] pred_sat;
	logic signed [34:0] sc_sh;
	logic signed [31:0] scale_new;

	// control
	always_comb begin
		out_free = !out_valid_q || out_ready;
		head_go  = (state_q == ST_IDLE) && !empty;
		pop      = head_go;
		mul_go   = (head_go && (head.op == msadpcm_pkg::OP_DATA)) || (state_q == ST_MUL_LO);
		fin_go   = ((state_q == ST_FIN_HI) || (state_q == ST_FIN_LO)) && out_free;
		mul_ch   = (state_q == ST_MUL_LO) ? cur_ch2_q : 1'b0;
		mul_nib  = (state_q == ST_MUL_LO) ? cur_byte_q[3:0] : head.data[7:4];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (head_go && (head.op == msadpcm_pkg::OP_DATA)) state_d = ST_FIN_HI;
			ST_FIN_HI: if (out_free) state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_FIN_LO;
			ST_FIN_LO: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// channel select for the product stage
	always_comb begin
		c1_sel    = c1_q[0];
		c2_sel    = c2_q[0];
		scale_sel = scale_q[0];
		prev_sel  = prev_q[0];
		older_sel = older_q[0];
		for (int g = 1; g < MAX_CHANNELS; g++) begin
			if (mul_ch == 1'(g)) begin
				c1_sel    = c1_q[g];
				c2_sel    = c2_q[g];
				scale_sel = scale_q[g];
				prev_sel  = prev_q[g];
				older_sel = older_q[g];
			end
		end
		sn        = signed'(mul_nib);
		adapt_sgn = signed'({1'b0, msadpcm_pkg::adapt_of(mul_nib)});
	end

	// product stage
	always_ff @(posedge clk) begin
		if (mul_go) begin
			prod1_s1 <= prev_sel * c1_sel;
			prod2_s1 <= older_sel * c2_sel;
			step_s1  <= sn * scale_sel;
			adapt_s1 <= adapt_sgn * scale_sel;
			ch_s1    <= mul_ch;
		end
	end

	// capture the data byte
	always_ff @(posedge clk) begin
		if (head_go && (head.op == msadpcm_pkg::OP_DATA)) begin
			cur_byte_q <= head.data[7:0];
			cur_ch2_q  <= head.ch2;
			cur_last_q <= head.last;
			cur_bad_q  <= head.bad;
		end
	end

	// finish stage: predictor with truncation toward zero, clamp, scale adaptation
	always_comb begin
		sum   = prod1_s1 + prod2_s1;
		sum_b = sum + (sum[27] ? msadpcm_pkg::TRUNC_BIAS : 28'sd0);
		quot  = sum_b[27:8];
		pred  = quot + step_s1;
		priority if (pred < msadpcm_pkg::SAMPLE_MIN)
			pred_sat = msadpcm_pkg::SAMPLE_MIN;
		else if (pred > msadpcm_pkg::SAMPLE_MAX)
			pred_sat = msadpcm_pkg::SAMPLE_MAX;
		else
			pred_sat = pred[15:0];
		sc_sh = adapt_s1[42:8];
		priority if (sc_sh < msadpcm_pkg::SCALE_MIN)
			scale_new = msadpcm_pkg::SCALE_MIN;
		else if (sc_sh > msadpcm_pkg::SCALE_MAX)
			scale_new = msadpcm_pkg::SCALE_MAX;
		else
			scale_new = sc_sh[31:0];
	end

	// channel state updates from header items and finished nibbles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < MAX_CHANNELS; g++) begin
				c1_q[g]    <= '0;
				c2_q[g]    <= '0;
				scale_q[g] <= '0;
				prev_q[g]  <= '0;
				older_q[g] <= '0;
			end
		end else begin
			for (int g = 0; g < MAX_CHANNELS; g++) begin
				if (head_go && (head.ch == 1'(g))) begin
					unique case (head.op)
						msadpcm_pkg::OP_COEF: begin
							c1_q[g] <= msadpcm_pkg::coef1_of(head.data[2:0]);
							c2_q[g] <= msadpcm_pkg::coef2_of(head.data[2:0]);
						end
						msadpcm_pkg::OP_SCALE: scale_q[g] <= 32'(signed'(head.data));
						msadpcm_pkg::OP_PREV:  prev_q[g]  <= head.data;
						msadpcm_pkg::OP_OLDER: older_q[g] <= head.data;
						default: ;
					endcase
				end
				if (fin_go && (ch_s1 == 1'(g))) begin
					older_q[g] <= prev_q[g];
					prev_q[g]  <= pred_sat;
					scale_q[g] <= scale_new;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_go)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			pcm_q  <= pred_sat;
			chan_q <= (state_q == ST_FIN_LO) ? cur_ch2_q : 1'b0;
			lob_q  <= state_q == ST_FIN_LO;
			eob_q  <= (state_q == ST_FIN_LO) && cur_last_q;
			bad_q  <= cur_bad_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign pcm_sample      = pcm_q;
	assign sample_channel  = chan_q;
	assign last_of_byte    = lob_q;
	assign end_of_block    = eob_q;
	assign bad_coeff_index = bad_q;

endmodule

/* sv/ms_adpcm_block_decoder_unit.sv */
// channel | dir    | handshake            | payload
// in      | sink   | in_valid / in_ready  | stream_byte
// out     | source | out_valid / out_ready| pcm_sample, sample_channel, last_of_byte,
//         |        |                      | end_of_block, bad_coeff_index
// cfg     | sink   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// the front takes one byte per cycle while the 4-item queue has room
// a data byte occupies the back end for a product step and a finish step per nibble,
// and the next nibble reads the state the last one wrote
// header words are taken by the back end in its idle state, their low bytes never reach it;
// the first sample of a byte passes the queue, the product stage and the output register
// arst_n clears position, flag, channel state and sets mono with 256 bytes per block
// out_ready low holds the finish stage, then fills the queue and drops in_ready
//
// top level of the ms adpcm block decoder; depends on msadpcm_pkg, msadpcm_front,
// msadpcm_queue, msadpcm_back and ms_adpcm_block_decoder_unit_macros.svh
`include "ms_adpcm_block_decoder_unit_macros.svh"

module ms_adpcm_block_decoder_unit #(
	parameter int MAX_BLOCK_BYTES = 4096,
	parameter int MAX_CHANNELS    = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          stream_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  pcm_sample,
	output logic                                sample_channel,
	output logic                                last_of_byte,
	output logic                                end_of_block,
	output logic                                bad_coeff_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [msadpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [msadpcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	msadpcm_pkg::qent_t q_in;
	msadpcm_pkg::qent_t q_head;

	// classification and block position
	msadpcm_front #(
		.MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
		.MAX_CHANNELS    (MAX_CHANNELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_byte (stream_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.push        (q_push),
		.entry       (q_in)
	);

	// item queue
	msadpcm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// decoder
	msadpcm_back #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (q_head),
		.empty           (q_empty),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pcm_sample      (pcm_sample),
		.sample_channel  (sample_channel),
		.last_of_byte    (last_of_byte),
		.end_of_block    (end_of_block),
		.bad_coeff_index (bad_coeff_index)
	);

	// checks
	`MSADPCM_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
	`MSADPCM_ASSERT_NXT(a_pop_frees, q_pop, !q_full, "queue full right after a pop")
	`MSADPCM_ASSERT_IMP(a_eob_second, out_valid && end_of_block, last_of_byte,
		"end of block on first sample of a byte")
	`MSADPCM_ASSERT_IMP(a_first_ch0, out_valid && !last_of_byte, !sample_channel,
		"first sample of a byte not on channel 0")

endmodule

/* tb/sv/ms_adpcm_block_decoder_unit_tb.sv */
// self-checking testbench for ms_adpcm_block_decoder_unit: a directed table of blocks and
// then random block streams under changing settings, checked against a local predictor or hand-worked samples
// depends on msadpcm_pkg and the decoder rtl
module ms_adpcm_block_decoder_unit_tb;

	localparam int BLOCK_LIMIT   = 4096;
	localparam int CHANNEL_LIMIT = 2;
	localparam int ITEMS_TARGET  = 950;
	localparam int SETTLE_CYCLES = 32;
	localparam int DRAIN_CAP     = 5000;
	localparam int LONG_HOLD     = 400;

	// adaptation gain per nibble and predictor coefficient pairs
	localparam int STEP_GAIN [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
		768, 614, 512, 409, 307, 230, 230, 230};
	localparam int PAIR_C1 [7] = '{256, 512, 0, 192, 240, 460, 392};
	localparam int PAIR_C2 [7] = '{0, -256, 0, 64, 0, -208, -232};

	typedef logic [msadpcm_pkg::CFG_DATA_W-1:0] cfg_word_t;

	// one decoded sample as it should leave the block
	typedef struct packed {
		logic signed [15:0] pcm;
		logic               chan;
		logic               second;
		logic               block_end;
		logic               bad_idx;
	} pcm_result_t;

	// directed table: register writes and bytes, some with hand-worked samples
	typedef enum logic {ROW_REG, ROW_BYTE} row_kind_t;
	typedef struct packed {
		row_kind_t                             kind;
		logic [msadpcm_pkg::CFG_IDX_W-1:0]     reg_idx;
		logic [msadpcm_pkg::CFG_DATA_W-1:0]    value;
		logic                                  typed;
		logic signed [15:0]                    s0;
		logic signed [15:0]                    s1;
	} stim_row_t;

	localparam int N_DIRECTED = 28;
	// the index column is unused on byte rows
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// mono, shortest block: one data byte after the header
		'{ROW_REG,  msadpcm_pkg::CFG_CHANNELS,    13'd1,   1'b0, 16'sd0, 16'sd0},
		'{ROW_REG,  msadpcm_pkg::CFG_BLOCK_BYTES, 13'd8,   1'b0, 16'sd0, 16'sd0},
		// index 255 is out of range, largest scale, extreme history
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'hFF,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'hFF,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h7F,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h80,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'hFF,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h7F,  1'b0, 16'sd0, 16'sd0},
		// both nibbles saturate high
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h77,  1'b1,
			msadpcm_pkg::SAMPLE_MAX, msadpcm_pkg::SAMPLE_MAX},
		// count 3 acts as stereo, length 0 is raised to the minimum
		'{ROW_REG,  msadpcm_pkg::CFG_CHANNELS,    13'd3,   1'b0, 16'sd0, 16'sd0},
		'{ROW_REG,  msadpcm_pkg::CFG_BLOCK_BYTES, 13'd0,   1'b0, 16'sd0, 16'sd0},
		// index 0 left, index 7 right (flagged)
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h07,  1'b0, 16'sd0, 16'sd0},
		// negative scale on the left, 16 on the right
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h80,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h10,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		// zero history on both sides
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h00,  1'b0, 16'sd0, 16'sd0},
		// negative scale times one, then saturation low
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h11,  1'b1,
			msadpcm_pkg::SAMPLE_MIN, 16'sd16},
		'{ROW_BYTE, msadpcm_pkg::CFG_CHANNELS,    13'h88,  1'b1,
			msadpcm_pkg::SAMPLE_MIN, -16'sd112}
	};

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  in_valid = 1'b0;
	logic                                  in_ready;
	logic [7:0]                            stream_byte = 8'd0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic signed [15:0]                    pcm_sample;
	logic                                  sample_channel;
	logic                                  last_of_byte;
	logic                                  end_of_block;
	logic                                  bad_coeff_index;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [msadpcm_pkg::CFG_IDX_W-1:0]     cfg_index = msadpcm_pkg::CFG_CHANNELS;
	logic [msadpcm_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

	// predictor copy of settings and decoder state
	logic [msadpcm_pkg::CHAN_W-1:0]        cfg_chan = msadpcm_pkg::CHAN_RESET;
	logic [msadpcm_pkg::BPC_W-1:0]         cfg_bpc = msadpcm_pkg::BPC_RESET;
	int                    blk_pos = 0;
	logic signed [10:0]    ch_c1 [CHANNEL_LIMIT] = '{default: '0};
	logic signed [8:0]     ch_c2 [CHANNEL_LIMIT] = '{default: '0};
	logic signed [31:0]    ch_step [CHANNEL_LIMIT] = '{default: '0};
	logic signed [15:0]    ch_s1 [CHANNEL_LIMIT] = '{default: '0};
	logic signed [15:0]    ch_s2 [CHANNEL_LIMIT] = '{default: '0};
	logic [7:0]            hold_lo = 8'd0;
	logic                  bad_seen = 1'b0;

	pcm_result_t expected_pcm [$];
	int mismatches = 0;
	int bytes_fed = 0;
	int samples_checked = 0;
	int blocks_closed = 0;
	int bad_samples = 0;

	ms_adpcm_block_decoder_unit #(
		.MAX_BLOCK_BYTES(BLOCK_LIMIT),
		.MAX_CHANNELS(CHANNEL_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pcm_sample(pcm_sample),
		.sample_channel(sample_channel),
		.last_of_byte(last_of_byte),
		.end_of_block(end_of_block),
		.bad_coeff_index(bad_coeff_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("ms_adpcm_block_decoder_unit_tb: errors");
		$finish;
	end

	// random gap, none inside a calm window
	function automatic bit idle_roll(input bit calm);
		return !calm && ($urandom_range(0, 99) < 25);
	endfunction

	// one nibble through the predictor and step adaptation of a channel
	function automatic logic signed [15:0] nibble_to_pcm(input int ch, input logic [3:0] nib);
		longint delta;
		longint est;
		longint next_step;
		delta = nib[3] ? longint'(nib) - 16 : longint'(nib);
		est = (longint'(ch_s1[ch]) * longint'(ch_c1[ch]) +
			longint'(ch_s2[ch]) * longint'(ch_c2[ch])) / 256;
		est += delta * longint'(ch_step[ch]);
		if (est < msadpcm_pkg::SAMPLE_MIN) est = longint'(msadpcm_pkg::SAMPLE_MIN);
		if (est > msadpcm_pkg::SAMPLE_MAX) est = longint'(msadpcm_pkg::SAMPLE_MAX);
		ch_s2[ch] = ch_s1[ch];
		ch_s1[ch] = est[15:0];
		next_step = longint'(STEP_GAIN[nib]) * longint'(ch_step[ch]) / 256;
		if (next_step < msadpcm_pkg::SCALE_MIN)
			next_step = longint'(msadpcm_pkg::SCALE_MIN);
		if (next_step > msadpcm_pkg::SCALE_MAX)
			next_step = longint'(msadpcm_pkg::SCALE_MAX);
		ch_step[ch] = next_step[31:0];
		return est[15:0];
	endfunction

	// register write; leaves cfg_valid up so writes can follow back to back
	task automatic write_reg(input logic [msadpcm_pkg::CFG_IDX_W-1:0] idx,
			input logic [msadpcm_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == msadpcm_pkg::CFG_CHANNELS) cfg_chan = val[msadpcm_pkg::CHAN_W-1:0];
		else cfg_bpc = val[msadpcm_pkg::BPC_W-1:0];
		@(negedge clk);
	endtask

	// hold the input, wait for every due sample, then let header work finish
	task automatic wait_drained();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_pcm.size() != 0 && waited < DRAIN_CAP) begin
			@(negedge clk);
			waited++;
		end
		if (expected_pcm.size() != 0) begin
			$error("%0d samples still due after %0d cycles", expected_pcm.size(), waited);
			mismatches++;
			expected_pcm.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// offer one byte, and on acceptance work out the samples it causes
	task automatic feed_byte(input logic [7:0] b, input bit typed,
			input logic signed [15:0] t0, input logic signed [15:0] t1);
		int nch;
		int bpc;
		int total;
		int hdr;
		int p;
		int q;
		int f;
		bit last;
		int ch2;
		pcm_result_t r0;
		pcm_result_t r1;
		while (idle_roll(bytes_fed >= 400 && bytes_fed < 550)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_fed++;
		// block geometry under the current settings
		nch = (cfg_chan >= 2) ? 2 : 1;
		if (nch > CHANNEL_LIMIT) nch = CHANNEL_LIMIT;
		bpc = int'(cfg_bpc);
		if (bpc < msadpcm_pkg::BPC_MIN) bpc = msadpcm_pkg::BPC_MIN;
		if (bpc > BLOCK_LIMIT) bpc = BLOCK_LIMIT;
		total = bpc * nch;
		hdr = msadpcm_pkg::HDR_PER_CH * nch;
		p = blk_pos;
		last = (p + 1 >= total);
		if (p == 0) bad_seen = 1'b0;
		if (p < nch) begin
			// coefficient pair index, out of range falls back to pair 0
			if (b <= msadpcm_pkg::COEF_IDX_MAX) begin
				ch_c1[p] = 11'(PAIR_C1[b]);
				ch_c2[p] = 9'(PAIR_C2[b]);
			end else begin
				ch_c1[p] = 11'(PAIR_C1[0]);
				ch_c2[p] = 9'(PAIR_C2[0]);
				bad_seen = 1'b1;
			end
		end else if (p < hdr) begin
			// little-endian words: scale, newer history, older history
			q = p - nch;
			f = q >> 1;
			if ((q & 1) == 0) hold_lo = b;
			else begin
				case (f / nch)
					0: ch_step[f % nch] = 32'(signed'({b, hold_lo}));
					1: ch_s1[f % nch] = {b, hold_lo};
					default: ch_s2[f % nch] = {b, hold_lo};
				endcase
			end
		end else begin
			// data byte: upper nibble left, lower nibble right in stereo
			ch2 = (nch == 2) ? 1 : 0;
			r0.pcm = nibble_to_pcm(0, b[7:4]);
			r0.chan = 1'b0;
			r0.second = 1'b0;
			r0.block_end = 1'b0;
			r0.bad_idx = bad_seen;
			r1.pcm = nibble_to_pcm(ch2, b[3:0]);
			r1.chan = ch2[0];
			r1.second = 1'b1;
			r1.block_end = last;
			r1.bad_idx = bad_seen;
			if (typed) begin
				r0.pcm = t0;
				r1.pcm = t1;
			end
			expected_pcm.push_back(r0);
			expected_pcm.push_back(r1);
		end
		blk_pos = last ? 0 : p + 1;
		@(negedge clk);
	endtask

	// result side: random stalls, one long hold, compare against the oldest due sample
	initial begin : sample_sink
		int hold_left;
		bit held_once;
		pcm_result_t due;
		hold_left = 0;
		held_once = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && samples_checked >= 150) begin
				held_once = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else out_ready <= !idle_roll(samples_checked >= 300 && samples_checked < 450);
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_pcm.size() == 0) begin
					$error("pcm_sample %0d arrived with nothing due", pcm_sample);
					mismatches++;
				end else begin
					due = expected_pcm.pop_front();
					if (pcm_sample !== due.pcm) begin
						$error("pcm_sample: expected %0d, got %0d", due.pcm, pcm_sample);
						mismatches++;
					end
					if (sample_channel !== due.chan) begin
						$error("sample_channel: expected %0d, got %0d", due.chan,
							sample_channel);
						mismatches++;
					end
					if (last_of_byte !== due.second) begin
						$error("last_of_byte: expected %0d, got %0d", due.second, last_of_byte);
						mismatches++;
					end
					if (end_of_block !== due.block_end) begin
						$error("end_of_block: expected %0d, got %0d", due.block_end,
							end_of_block);
						mismatches++;
					end
					if (bad_coeff_index !== due.bad_idx) begin
						$error("bad_coeff_index: expected %0d, got %0d", due.bad_idx,
							bad_coeff_index);
						mismatches++;
					end
					samples_checked++;
					if (due.block_end) blocks_closed++;
					if (due.bad_idx) bad_samples++;
				end
			end
		end
	end

	// byte side: reset, directed table, random phases, wrap-up
	initial begin : byte_source
		bit cfg_open;
		int phases;
		int kind;
		int count;
		int pause_at;
		int nch;
		int hdr;
		logic [1:0] chan_raw;
		cfg_word_t bpc_val;
		cfg_word_t chan_val;
		logic [7:0] b;
		cfg_open = 0;
		phases = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				if (!cfg_open) wait_drained();
				write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
				cfg_open = 1;
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 0;
				end
				feed_byte(DIRECTED[i].value[7:0], DIRECTED[i].typed, DIRECTED[i].s0,
					DIRECTED[i].s1);
			end
		end

		// random phases, each under fresh settings, usually cut off mid-block
		while (bytes_fed < ITEMS_TARGET) begin
			wait_drained();
			kind = $urandom_range(0, 9);
			if (kind <= 1 || $urandom_range(0, 4) == 0) chan_raw = 2'($urandom_range(0, 3));
			else chan_raw = 2'($urandom_range(1, 2));
			case (kind)
				0: begin
					// longest blocks, saturated above the maximum
					bpc_val = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
					if ($urandom_range(0, 2) == 0) bpc_val = cfg_word_t'($urandom_range(4097, 8190));
					count = $urandom_range(40, 70);
				end
				1: begin
					// below the minimum length
					bpc_val = cfg_word_t'($urandom_range(0, 7));
					count = $urandom_range(30, 80);
				end
				default: begin
					bpc_val = ($urandom_range(0, 5) == 0) ? cfg_word_t'($urandom_range(8, 64))
						: cfg_word_t'($urandom_range(8, 24));
					count = $urandom_range(40, 110);
				end
			endcase
			chan_val = cfg_word_t'($urandom);
			chan_val[msadpcm_pkg::CHAN_W-1:0] = chan_raw;
			write_reg(msadpcm_pkg::CFG_CHANNELS, chan_val);
			write_reg(msadpcm_pkg::CFG_BLOCK_BYTES, bpc_val);
			cfg_valid <= 1'b0;
			pause_at = $urandom_range(0, count - 1);
			for (int k = 0; k < count; k++) begin
				// now and then the sender waits for everything to come out
				if (k == pause_at && phases % 3 == 0) wait_drained();
				nch = (cfg_chan >= 2) ? 2 : 1;
				hdr = msadpcm_pkg::HDR_PER_CH * nch;
				if ($urandom_range(0, 19) == 0) b = 8'($urandom);
				else if (blk_pos < nch) begin
					b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 255))
						: 8'($urandom_range(0, msadpcm_pkg::COEF_IDX_MAX));
				end else if (blk_pos < hdr && ((blk_pos - nch) >> 1) / nch == 0) begin
					// scale word, mostly a moderate positive step
					if (((blk_pos - nch) & 1) == 0) b = 8'($urandom);
					else b = ($urandom_range(0, 9) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, 3));
				end else b = 8'($urandom);
				feed_byte(b, 1'b0, 16'sd0, 16'sd0);
			end
			phases++;
		end

		wait_drained();
		$display("covered %0d bytes over %0d random settings phases, %0d samples compared",
			bytes_fed, phases, samples_checked);
		$display("%0d block ends, %0d samples under a flagged coefficient index, %0d mismatches",
			blocks_closed, bad_samples, mismatches);
		if (mismatches == 0) $display("ms_adpcm_block_decoder_unit_tb: clean");
		else $display("ms_adpcm_block_decoder_unit_tb: errors");
		$finish;
	end

endmodule
